// File: rtl/mmnr_pkg.sv
`timescale 1ns / 1ps

package mmnr_pkg;

    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

    localparam logic       EV_RETRIGGER  = 1'b0;
    localparam logic       EV_RELEASE    = 1'b1;

    localparam logic [7:0] RESET_PITCH   = 8'd69;
    localparam int         STEP_W        = 24;

    // one complete note-on or note-off message
    typedef struct packed {
        logic       note_on;
        logic [7:0] pitch;
        logic [7:0] velocity;
    } msg_t;

    function automatic logic [STEP_W-1:0] base_step(input logic [3:0] semitone);
        logic [STEP_W-1:0] s;
        begin
            unique case (semitone)
                4'd0:    s = 24'h0EBC19;
                4'd1:    s = 24'h0F9C66;
                4'd2:    s = 24'h108A09;
                4'd3:    s = 24'h1185CE;
                4'd4:    s = 24'h12908B;
                4'd5:    s = 24'h13AB25;
                4'd6:    s = 24'h14D68D;
                4'd7:    s = 24'h1613C2;
                4'd8:    s = 24'h1763D4;
                4'd9:    s = 24'h18C7E3;
                4'd10:   s = 24'h1A411D;
                4'd11:   s = 24'h1BD0C5;
                default: s = '0;
            endcase
            return s;
        end
    endfunction

    // pitch / 12 as ((pitch >> 2) * 43) >> 7, exact for 8-bit pitch
    function automatic logic [STEP_W-1:0] step_for(input logic [7:0] pitch);
        logic [11:0]       prod;
        logic [4:0]        octave;
        logic [8:0]        octave_x12;
        logic [3:0]        semitone;
        logic [STEP_W-1:0] shifted;
        begin
            prod       = {6'd0, pitch[7:2]} * 12'd43;
            octave     = prod[11:7];
            octave_x12 = {4'd0, octave} * 9'd12;
            semitone   = 4'(({1'b0, pitch} - octave_x12));
            shifted    = base_step(semitone) << octave;
            return shifted;
        end
    endfunction

endpackage

// File: rtl/mmnr_if.sv
`timescale 1ns / 1ps

interface mmnr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mmnr_event_if;
    logic        valid;
    logic        ready;
    logic        event_res;
    logic [7:0]  note_pitch;
    logic [7:0]  note_velocity;
    logic [23:0] step_size;

    modport source (output valid, output event_res, output note_pitch,
                    output note_velocity, output step_size, input ready);
    modport sink   (input valid, input event_res, input note_pitch,
                    input note_velocity, input step_size, output ready);
endinterface

// File: rtl/mono_midi_note_receiver_top.sv
`timescale 1ns / 1ps

// Monophonic MIDI note receiver: takes one MIDI byte per request on midi_in
// and sends a retrigger or release request on note_out for note-on/note-off
// messages (channel ignored, no running status). A new byte is accepted
// every cycle while the pipeline moves; a byte that completes a message
// passes the parser register and then the voice register. The held note
// resets to pitch 69 and step 0, the output velocity to 0, and the step
// is the semitone base step shifted left by the octave.
module mono_midi_note_receiver_top (
    input  logic          clk,
    input  logic          rst_n,
    mmnr_byte_if.sink     midi_in,
    mmnr_event_if.source  note_out
);

    logic           msg_valid;
    logic           msg_ready;
    mmnr_pkg::msg_t msg;

    mmnr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .midi_in   (midi_in),
        .msg_valid (msg_valid),
        .msg       (msg),
        .msg_ready (msg_ready)
    );

    mmnr_voice u_voice (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg       (msg),
        .msg_ready (msg_ready),
        .note_out  (note_out)
    );

endmodule

// File: rtl/mmnr_parser.sv
`timescale 1ns / 1ps

module mmnr_parser (
    input  logic              clk,
    input  logic              rst_n,
    mmnr_byte_if.sink         midi_in,
    output logic              msg_valid,
    output mmnr_pkg::msg_t    msg,
    input  logic              msg_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DATA1,
        ST_DATA2
    } state_t;

    state_t         state_reg;
    logic [3:0]     kind_reg;
    logic [7:0]     first_reg;
    logic           msg_valid_reg;
    mmnr_pkg::msg_t msg_reg;
    logic           accept;

    assign midi_in.ready = !msg_valid_reg || msg_ready;
    assign accept        = midi_in.valid && midi_in.ready;
    assign msg_valid     = msg_valid_reg;
    assign msg           = msg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= '0;
            first_reg     <= '0;
            msg_valid_reg <= 1'b0;
            msg_reg       <= '0;
        end
        else
        begin
            if (msg_ready)
            begin
                msg_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                        // data bytes are dropped while waiting for status
                        if (midi_in.rx_byte[7])
                        begin
                            kind_reg  <= midi_in.rx_byte[7:4];
                            state_reg <= ST_DATA1;
                        end
                    end
                    ST_DATA1:
                    begin
                        first_reg <= midi_in.rx_byte;
                        state_reg <= ST_DATA2;
                    end
                    ST_DATA2:
                    begin
                        state_reg <= ST_IDLE;
                        if (kind_reg == mmnr_pkg::KIND_NOTE_ON ||
                            kind_reg == mmnr_pkg::KIND_NOTE_OFF)
                        begin
                            msg_valid_reg    <= 1'b1;
                            msg_reg.note_on  <= (kind_reg == mmnr_pkg::KIND_NOTE_ON);
                            msg_reg.pitch    <= first_reg;
                            msg_reg.velocity <= midi_in.rx_byte;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// File: rtl/mmnr_voice.sv
`timescale 1ns / 1ps

module mmnr_voice (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              msg_valid,
    input  mmnr_pkg::msg_t    msg,
    output logic              msg_ready,
    mmnr_event_if.source      note_out
);

    logic [7:0]                  held_pitch_reg;
    logic [mmnr_pkg::STEP_W-1:0] held_step_reg;

    logic                        out_valid_reg;
    logic                        out_event_reg;
    logic [7:0]                  out_pitch_reg;
    logic [7:0]                  out_velocity_reg;
    logic [mmnr_pkg::STEP_W-1:0] out_step_reg;

    logic                        take;
    logic                        retrigger;
    logic                        release_hit;
    logic [mmnr_pkg::STEP_W-1:0] step_next;

    assign msg_ready   = !out_valid_reg || note_out.ready;
    assign take        = msg_valid && msg_ready;
    assign retrigger   = take && msg.note_on && (msg.velocity != 8'd0);
    // zero-velocity note-on counts as note-off
    assign release_hit = take && !retrigger && (msg.pitch == held_pitch_reg);
    assign step_next   = mmnr_pkg::step_for(msg.pitch);

    assign note_out.valid         = out_valid_reg;
    assign note_out.event_res     = out_event_reg;
    assign note_out.note_pitch    = out_pitch_reg;
    assign note_out.note_velocity = out_velocity_reg;
    assign note_out.step_size     = out_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_pitch_reg    <= mmnr_pkg::RESET_PITCH;
            held_step_reg     <= '0;
            out_valid_reg     <= 1'b0;
            out_event_reg     <= mmnr_pkg::EV_RETRIGGER;
            out_pitch_reg     <= '0;
            out_velocity_reg  <= '0;
            out_step_reg      <= '0;
        end
        else
        begin
            if (note_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (retrigger)
            begin
                held_pitch_reg    <= msg.pitch;
                held_step_reg     <= step_next;
                out_valid_reg     <= 1'b1;
                out_event_reg     <= mmnr_pkg::EV_RETRIGGER;
                out_pitch_reg     <= msg.pitch;
                out_velocity_reg  <= msg.velocity;
                out_step_reg      <= step_next;
            end
            else if (release_hit)
            begin
                out_valid_reg     <= 1'b1;
                out_event_reg     <= mmnr_pkg::EV_RELEASE;
                out_pitch_reg     <= held_pitch_reg;
                out_velocity_reg  <= '0;
                out_step_reg      <= held_step_reg;
            end
        end
    end

endmodule

// File: tb/mono_midi_note_receiver_top_tb.sv
`timescale 1ns / 1ps

module mono_midi_note_receiver_top_tb;

    typedef enum logic [1:0] {
        WAIT_STATUS,
        WAIT_FIRST,
        WAIT_SECOND
    } parse_pos_t;

    typedef struct packed {
        logic        event_res;
        logic [7:0]  pitch;
        logic [7:0]  velocity;
        logic [23:0] step;
    } note_event_t;

    logic clk;
    logic rst_n;

    mmnr_byte_if  midi_if ();
    mmnr_event_if note_if ();

    mono_midi_note_receiver_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .midi_in  (midi_if),
        .note_out (note_if)
    );

    // parser and voice state as the block should hold it
    parse_pos_t  parse_pos;
    logic [3:0]  msg_kind;
    logic [7:0]  first_byte;
    logic [7:0]  held_pitch;
    logic [7:0]  held_velocity;
    logic [23:0] held_step;

    note_event_t pending_notes[$];
    int          mismatch_count;
    int          consumed_bytes;
    bit          idle_enabled;
    int          hold_left;
    int          stall_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [23:0] semitone_step(input logic [3:0] semi);
        logic [23:0] s;
        case (semi)
            4'd0:    s = 24'h0EBC19;
            4'd1:    s = 24'h0F9C66;
            4'd2:    s = 24'h108A09;
            4'd3:    s = 24'h1185CE;
            4'd4:    s = 24'h12908B;
            4'd5:    s = 24'h13AB25;
            4'd6:    s = 24'h14D68D;
            4'd7:    s = 24'h1613C2;
            4'd8:    s = 24'h1763D4;
            4'd9:    s = 24'h18C7E3;
            4'd10:   s = 24'h1A411D;
            default: s = 24'h1BD0C5;
        endcase
        return s;
    endfunction

    function automatic logic [23:0] osc_step(input logic [7:0] pitch);
        int          octave;
        logic [47:0] wide;
        octave = pitch / 12;
        wide   = {24'd0, semitone_step(4'(pitch % 12))} << octave;
        return wide[23:0];
    endfunction

    // returns 1 when the parser takes the byte, 0 when it is dropped
    function automatic bit track_midi_byte(input logic [7:0] b);
        note_event_t ev;
        case (parse_pos)
            WAIT_FIRST:
            begin
                first_byte = b;
                parse_pos  = WAIT_SECOND;
                return 1'b1;
            end
            WAIT_SECOND:
            begin
                parse_pos = WAIT_STATUS;
                if (msg_kind == mmnr_pkg::KIND_NOTE_ON && b != 8'd0)
                begin
                    held_pitch    = first_byte;
                    held_velocity = b;
                    held_step     = osc_step(first_byte);
                    ev = '{mmnr_pkg::EV_RETRIGGER, held_pitch, held_velocity, held_step};
                    pending_notes.push_back(ev);
                end
                else if ((msg_kind == mmnr_pkg::KIND_NOTE_ON ||
                          msg_kind == mmnr_pkg::KIND_NOTE_OFF) &&
                         held_pitch == first_byte)
                begin
                    held_velocity = 8'd0;
                    ev = '{mmnr_pkg::EV_RELEASE, held_pitch, held_velocity, held_step};
                    pending_notes.push_back(ev);
                end
                return 1'b1;
            end
            default:
            begin
                if (b[7])
                begin
                    msg_kind  = b[7:4];
                    parse_pos = WAIT_FIRST;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            midi_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        midi_if.valid   <= 1'b1;
        midi_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!midi_if.ready);
        if (track_midi_byte(b))
            consumed_bytes++;
    endtask

    task automatic send_message(input logic [7:0] status, input logic [7:0] d1,
                                input logic [7:0] d2);
        send_byte(status);
        send_byte(d1);
        send_byte(d2);
    endtask

    // the sender stops offering while the block empties
    task automatic wait_drained();
        midi_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_notes.size() != 0);
    endtask

    // sink side: takes results, compares them, and stalls at random
    always @(posedge clk)
    begin : note_sink
        note_event_t want;
        if (rst_n)
        begin
            if (note_if.valid && note_if.ready)
            begin
                if (pending_notes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected note request: ev=%0d pitch=%0d vel=%0d step=%h",
                                 note_if.event_res, note_if.note_pitch,
                                 note_if.note_velocity, note_if.step_size);
                end
                else
                begin
                    want = pending_notes.pop_front();
                    if (note_if.event_res !== want.event_res ||
                        note_if.note_pitch !== want.pitch ||
                        note_if.note_velocity !== want.velocity ||
                        note_if.step_size !== want.step)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("note mismatch: exp %0d/%0d/%0d/%h got %0d/%0d/%0d/%h",
                                     want.event_res, want.pitch, want.velocity, want.step,
                                     note_if.event_res, note_if.note_pitch,
                                     note_if.note_velocity, note_if.step_size);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                note_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                note_if.ready <= 1'b0;
            end
            else
            begin
                note_if.ready <= 1'b1;
                if ($urandom_range(0, 99) < 15)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic test_directed();
        // release for the reset pitch before any note-on
        send_message(8'h80, mmnr_pkg::RESET_PITCH, 8'h00);
        // data bytes while idle are dropped
        send_byte(8'h05);
        send_byte(8'h7F);
        send_message(8'h90, 8'h00, 8'h01);
        // status values in data slots, pitch above 127 with the widest shift
        send_message(8'h9F, 8'hFF, 8'hFF);
        send_message(8'h8F, 8'hFF, 8'h40);
        send_message(8'h90, 8'h7F, 8'h80);
        // note-off for a pitch that is not held does nothing
        send_message(8'h80, 8'h10, 8'h00);
        // controller message is swallowed whole
        send_message(8'hB3, 8'h90, 8'h7F);
        // note-on with zero velocity releases the held pitch
        send_message(8'h9A, 8'h7F, 8'h00);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int target);
        int          stop_at;
        int          r;
        logic [7:0]  status;
        logic [7:0]  pitch;
        logic [7:0]  vel;
        stop_at = consumed_bytes + target;
        while (consumed_bytes < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                status = {($urandom_range(0, 1) ? mmnr_pkg::KIND_NOTE_ON
                                                : mmnr_pkg::KIND_NOTE_OFF),
                          4'($urandom_range(0, 15))};
                r = $urandom_range(0, 99);
                if (r < 40)
                    pitch = held_pitch;
                else if (r < 80)
                    pitch = 8'($urandom_range(0, 127));
                else
                    pitch = 8'($urandom_range(0, 255));
                vel = ($urandom_range(0, 99) < 15) ? 8'd0 : 8'($urandom_range(1, 255));
                send_message(status, pitch, vel);
            end
            else if (r < 85)
            begin
                send_message(8'($urandom_range(8'h80, 8'hFF)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
            end
            else
            begin
                // stray byte, may also cut a later message short
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_output_stall();
        int i;
        wait_drained();
        idle_enabled = 1'b0;
        hold_left    = 300;
        for (i = 0; i < 12; i++)
            send_message(8'h90 | 8'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(1, 255)));
        idle_enabled = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        midi_if.valid   = 1'b0;
        midi_if.rx_byte = 8'h00;
        note_if.ready   = 1'b0;
        mismatch_count  = 0;
        consumed_bytes  = 0;
        idle_enabled    = 1'b1;
        hold_left       = 0;
        stall_left      = 0;
        parse_pos       = WAIT_STATUS;
        msg_kind        = 4'h0;
        first_byte      = 8'h00;
        held_pitch      = mmnr_pkg::RESET_PITCH;
        held_velocity   = 8'd0;
        held_step       = 24'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(200);
        // back to back on the input side
        idle_enabled = 1'b0;
        test_random_traffic(60);
        idle_enabled = 1'b1;
        test_output_stall();
        test_random_traffic(150);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_notes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/mmnr_pkg.sv
rtl/mmnr_if.sv
rtl/mmnr_parser.sv
rtl/mmnr_voice.sv
rtl/mono_midi_note_receiver_top.sv
tb/mono_midi_note_receiver_top_tb.sv
